FILE: sv/rrwl_pkg.sv
package rrwl_pkg;

    // lock state widths
    localparam int ID_BITS          = 16;
    localparam int READ_COUNT_BITS  = 16;
    localparam int WRITE_COUNT_BITS = 16;

    // stream field widths
    localparam int OP_W     = 2;
    localparam int REQ_ID_W = 16;
    localparam int STATUS_W = 3;
    localparam int FIELD_W  = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef logic [OP_W-1:0]             t_op;
    typedef logic [STATUS_W-1:0]         t_status;
    typedef logic [ID_BITS-1:0]          t_id;
    typedef logic [READ_COUNT_BITS-1:0]  t_rd_cnt;
    typedef logic [WRITE_COUNT_BITS-1:0] t_wr_cnt;
    typedef logic [FIELD_W-1:0]          t_field;

    localparam t_op OP_WLOCK   = 2'd0;
    localparam t_op OP_WUNLOCK = 2'd1;
    localparam t_op OP_RLOCK   = 2'd2;
    localparam t_op OP_RUNLOCK = 2'd3;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BUSY     = 3'd1;
    localparam t_status ST_ORDER    = 3'd2;
    localparam t_status ST_NOTHELD  = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;

    typedef struct packed {
        t_status status;
        t_field  owner_now;
        t_field  readers_now;
    } t_result;

endpackage

FILE: sv/rrwl_core.sv
module rrwl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rrwl_pkg::t_op     i_op,
    input  rrwl_pkg::t_id     i_id,
    output rrwl_pkg::t_result o_res
);

    rrwl_pkg::t_id     r_owner, n_owner;
    rrwl_pkg::t_wr_cnt r_wr_depth, n_wr_depth;
    rrwl_pkg::t_rd_cnt r_rd_depth, n_rd_depth;
    rrwl_pkg::t_status n_status;

    always_comb begin
        n_owner    = r_owner;
        n_wr_depth = r_wr_depth;
        n_rd_depth = r_rd_depth;
        n_status   = rrwl_pkg::ST_OK;
        case (i_op)
            rrwl_pkg::OP_WLOCK: begin
                if (i_id == '0) begin
                    n_status = rrwl_pkg::ST_BUSY;
                end else if (r_owner == i_id) begin
                    // recursion by the owner, saturating
                    if (r_wr_depth == '1) begin
                        n_status = rrwl_pkg::ST_OVERFLOW;
                    end else begin
                        n_wr_depth = r_wr_depth + rrwl_pkg::t_wr_cnt'(1);
                    end
                end else if (r_owner == '0 && r_rd_depth == '0) begin
                    n_owner    = i_id;
                    n_wr_depth = rrwl_pkg::t_wr_cnt'(1);
                end else begin
                    n_status = rrwl_pkg::ST_BUSY;
                end
            end
            rrwl_pkg::OP_WUNLOCK: begin
                if (i_id == '0 || r_owner != i_id) begin
                    n_status = rrwl_pkg::ST_NOTHELD;
                end else if (r_rd_depth != '0) begin
                    n_status = rrwl_pkg::ST_ORDER;
                end else if (r_wr_depth <= rrwl_pkg::t_wr_cnt'(1)) begin
                    n_owner    = '0;
                    n_wr_depth = '0;
                end else begin
                    n_wr_depth = r_wr_depth - rrwl_pkg::t_wr_cnt'(1);
                end
            end
            rrwl_pkg::OP_RLOCK: begin
                if (r_owner != '0 && r_owner != i_id) begin
                    n_status = rrwl_pkg::ST_BUSY;
                end else if (r_rd_depth == '1) begin
                    n_status = rrwl_pkg::ST_OVERFLOW;
                end else begin
                    n_rd_depth = r_rd_depth + rrwl_pkg::t_rd_cnt'(1);
                end
            end
            rrwl_pkg::OP_RUNLOCK: begin
                // any requester may drop a read
                if (r_rd_depth == '0) begin
                    n_status = rrwl_pkg::ST_NOTHELD;
                end else begin
                    n_rd_depth = r_rd_depth - rrwl_pkg::t_rd_cnt'(1);
                end
            end
            default: begin
                n_status = rrwl_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner    <= '0;
            r_wr_depth <= '0;
            r_rd_depth <= '0;
        end else if (i_step) begin
            r_owner    <= n_owner;
            r_wr_depth <= n_wr_depth;
            r_rd_depth <= n_rd_depth;
        end
    end

    assign o_res.status      = n_status;
    assign o_res.owner_now   = rrwl_pkg::t_field'(n_owner);
    assign o_res.readers_now = rrwl_pkg::t_field'(n_rd_depth);

endmodule

FILE: sv/recursive_reader_writer_lock_top.sv
// an accepted request word passes through the request register and then the reply register to the master side
// throughput: one request per cycle unless the master side stalls; the lock state registers update once per request
// a stalled master side holds the reply register and backs up into the request register
// reset: i_rst_n synchronous, active low; clears writer id, write and read counts
// and empties both word registers
module recursive_reader_writer_lock_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // op [1:0], requester_id [17:2], zero fill [23:18]
    input  logic [rrwl_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // status [2:0], owner_now [18:3], readers_now [34:19], zero fill [39:35]
    output logic [rrwl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready
);

    logic              r_in_valid;
    rrwl_pkg::t_op     r_op;
    rrwl_pkg::t_field  r_req_id;
    logic              r_out_valid;
    rrwl_pkg::t_result r_out;
    rrwl_pkg::t_result w_res;
    logic              w_out_free;
    logic              w_step;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op     <= i_s_tdata[1:0];
            r_req_id <= i_s_tdata[17:2];
        end
    end

    rrwl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_op    (r_op),
        .i_id    (rrwl_pkg::t_id'(r_req_id)),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.readers_now, r_out.owner_now, r_out.status};

endmodule

FILE: sv/rrwl_checker.sv
module rrwl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic [rrwl_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready
);

    // no reply word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("reply word present after reset");

    // stalled reply word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("reply word changed while stalled");

    // status code is one of the defined replies
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= rrwl_pkg::ST_OVERFLOW)
        else $error("undefined status code");

    // order violation only while a writer and readers are both present
    a_order_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] == rrwl_pkg::ST_ORDER
            |-> o_m_tdata[18:3] != '0 && o_m_tdata[34:19] != '0)
        else $error("order violation reported without writer and readers");

endmodule

bind recursive_reader_writer_lock_top rrwl_checker u_rrwl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

FILE: test/tb_recursive_reader_writer_lock_top.sv
`timescale 1ns / 1ps

module tb_recursive_reader_writer_lock_top;

    import rrwl_pkg::*;

    typedef struct {
        t_op     op;
        t_id     id;
        t_status status;
        t_field  owner_now;
        t_field  readers_now;
    } t_lock_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;

    // lock state as the testbench expects it
    t_id     writer_id = '0;
    t_wr_cnt write_cnt = '0;
    t_rd_cnt read_cnt = '0;

    t_lock_reply pending_replies[$];
    int          mismatch_cnt = 0;
    bit          no_idle = 1'b0;

    recursive_reader_writer_lock_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lock_reply predict_lock_reply(input t_op op, input t_id id);
        t_lock_reply r;
        t_status     st;
        st = ST_OK;
        case (op)
            OP_WLOCK: begin
                if (id == '0) begin
                    st = ST_BUSY;
                end else if (writer_id == id) begin
                    if (write_cnt == '1) st = ST_OVERFLOW;
                    else write_cnt = write_cnt + 1'b1;
                end else if (writer_id == '0 && read_cnt == '0) begin
                    writer_id = id;
                    write_cnt = t_wr_cnt'(1);
                end else begin
                    st = ST_BUSY;
                end
            end
            OP_WUNLOCK: begin
                if (id == '0 || writer_id != id) begin
                    st = ST_NOTHELD;
                end else if (read_cnt != '0) begin
                    st = ST_ORDER;
                end else if (write_cnt <= 1) begin
                    write_cnt = '0;
                    writer_id = '0;
                end else begin
                    write_cnt = write_cnt - 1'b1;
                end
            end
            OP_RLOCK: begin
                // the writer itself may also take reads
                if (writer_id != '0 && writer_id != id) st = ST_BUSY;
                else if (read_cnt == '1) st = ST_OVERFLOW;
                else read_cnt = read_cnt + 1'b1;
            end
            default: begin
                // read release is not tied to an id
                if (read_cnt == '0) st = ST_NOTHELD;
                else read_cnt = read_cnt - 1'b1;
            end
        endcase
        r.op          = op;
        r.id          = id;
        r.status      = st;
        r.owner_now   = t_field'(writer_id);
        r.readers_now = t_field'(read_cnt);
        return r;
    endfunction

    task automatic send_req(input t_op op, input t_id id);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 24) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  <= {{(IN_TDATA_W - REQ_ID_W - OP_W){1'b0}}, id, op};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_replies.push_back(predict_lock_reply(op, id));
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin : reply_check
        t_lock_reply exp_r;
        t_status     got_status;
        t_field      got_owner;
        t_field      got_readers;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_status  = o_m_tdata[2:0];
            got_owner   = o_m_tdata[18:3];
            got_readers = o_m_tdata[34:19];
            if (pending_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected reply word: status %0d owner %h readers %0d",
                             got_status, got_owner, got_readers);
            end else begin
                exp_r = pending_replies.pop_front();
                if (got_status != exp_r.status || got_owner != exp_r.owner_now ||
                    got_readers != exp_r.readers_now) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch op %0d id %h: expected status %0d owner %h ",
                                  "readers %0d, got status %0d owner %h readers %0d"},
                                 exp_r.op, exp_r.id, exp_r.status, exp_r.owner_now,
                                 exp_r.readers_now, got_status, got_owner, got_readers);
                end
            end
        end
    end

    task automatic test_directed();
        send_req(OP_WLOCK, 16'h0000);      // id zero never owns
        send_req(OP_RUNLOCK, 16'h0001);    // nothing to release
        send_req(OP_WUNLOCK, 16'h0005);    // no writer
        send_req(OP_WUNLOCK, 16'h0000);
        send_req(OP_WLOCK, 16'hFFFF);
        send_req(OP_WLOCK, 16'hFFFF);      // recursion
        send_req(OP_WLOCK, 16'h0001);
        send_req(OP_RLOCK, 16'h0001);      // other id while written
        send_req(OP_RLOCK, 16'hFFFF);      // writer reads
        send_req(OP_WUNLOCK, 16'h0001);    // not the owner
        send_req(OP_WUNLOCK, 16'hFFFF);    // reads still held
        send_req(OP_RUNLOCK, 16'h1234);    // anyone may drop a read
        send_req(OP_WUNLOCK, 16'hFFFF);
        send_req(OP_WUNLOCK, 16'hFFFF);
        send_req(OP_RLOCK, 16'h0001);
        send_req(OP_RLOCK, 16'h0000);
        send_req(OP_WLOCK, 16'h0002);      // readers block a writer
        send_req(OP_RUNLOCK, 16'h0003);
        send_req(OP_RUNLOCK, 16'h0004);
        send_req(OP_WLOCK, 16'hAAAA);
        send_req(OP_WUNLOCK, 16'h5555);
        send_req(OP_WUNLOCK, 16'hAAAA);
        send_req(OP_WLOCK, 16'h8000);
        send_req(OP_WUNLOCK, 16'h8000);
    endtask

    task automatic test_random();
        t_id pool[3];
        t_op op;
        t_id id;
        int  pick;
        for (int n = 0; n < 750; n++) begin
            if (n % 40 == 0) begin
                foreach (pool[k]) pool[k] = t_id'($urandom_range(1, 65535));
                if ($urandom_range(3) == 0) pool[0] = 16'hFFFF;
            end
            no_idle = (n >= 300 && n < 480);
            op   = t_op'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 4) id = '0;
            else if (pick < 14) id = t_id'($urandom);
            else if (pick < 28 && writer_id != '0) id = writer_id;
            else id = pool[$urandom_range(2)];
            // keep the read count low so writers get a chance
            if (op == OP_RLOCK && read_cnt > 4 && $urandom_range(1) == 0) op = OP_RUNLOCK;
            send_req(op, id);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
            $display("recursive_reader_writer_lock_top regression: pass");
        end else begin
            $display("recursive_reader_writer_lock_top regression: fail");
        end
        $finish;
    end

    initial begin
        #(64'd60_000_000);
        $display("recursive_reader_writer_lock_top regression: fail");
        $finish;
    end

endmodule
